>>> hdl/lpht_pkg.sv
// Shared constants and types of the linear probing hash table.
package lpht_pkg;

  localparam int MAX_SLOTS    = 16;
  localparam int SLOT_W       = $clog2(MAX_SLOTS);
  localparam int SIZE_W       = $clog2(MAX_SLOTS + 1);
  localparam int KEY_W        = 31;
  localparam int TS_W         = 5;
  localparam int SLOT_IDX_W   = 4;
  localparam int KEY_PAD_W    = 32;
  localparam int MOD_BITS     = 4;
  localparam int MOD_STEPS    = KEY_PAD_W / MOD_BITS;
  localparam int MOD_CNT_W    = $clog2(MOD_STEPS);
  localparam int PADDR_W      = 3;
  localparam int PDATA_W      = 32;
  localparam logic [TS_W-1:0] TABLE_SIZE_RESET = TS_W'(10);

  localparam logic REQ_INSERT = 1'b0;
  localparam logic REQ_SEARCH = 1'b1;

  localparam logic REG_IDX_TABLE_SIZE = 1'b0;

  typedef enum logic [1:0] {
    ST_INSERTED = 2'd0,
    ST_FULL     = 2'd1,
    ST_FOUND    = 2'd2,
    ST_MISSING  = 2'd3
  } status_e;

  typedef enum logic [2:0] {
    FSM_IDLE,
    FSM_MODULO,
    FSM_SEED,
    FSM_READ,
    FSM_CHECK
  } fsm_e;

  typedef struct packed {
    logic    load;
    logic    mod_step;
    logic    seed;
    logic    read;
    logic    advance;
    logic    write;
    logic    result_load;
    status_e result_status;
  } cmd_t;

  typedef struct packed {
    logic is_search;
    logic occ;
    logic match;
    logic last;
  } stat_t;

endpackage

>>> hdl/lpht_dp.sv
// Datapath of the hash table: request registers, modulo unit, probe walk and slot storage.
module lpht_dp
  import lpht_pkg::*;
(
  input  logic                  clk_i,
  input  logic                  rst_ni,
  input  cmd_t                  cmd_i,
  output stat_t                 stat_o,
  input  logic [TS_W-1:0]       table_size_i,
  input  logic                  req_type_i,
  input  logic [KEY_W-1:0]      key_i,
  output logic [1:0]            status_o,
  output logic [SLOT_IDX_W-1:0] slot_index_o
);

  logic [KEY_W-1:0]      key_q;
  logic                  type_q;
  logic [KEY_PAD_W-1:0]  key_sh_q;
  logic [SIZE_W-1:0]     rem_q, rem_d;
  logic [SLOT_W-1:0]     pos_q, pos_nx;
  logic [SLOT_W-1:0]     cnt_q;
  logic [SIZE_W-1:0]     pos_inc;
  logic [SIZE_W-1:0]     n_eff;
  logic [SIZE_W:0]       mod_w;
  logic [SIZE_W-1:0]     mod_t;
  logic [KEY_W-1:0]      keys_mem [MAX_SLOTS];
  logic [MAX_SLOTS-1:0]  occ_q;
  logic [KEY_W-1:0]      rd_key_q;
  logic                  rd_occ_q;
  status_e               status_q;
  logic [SLOT_IDX_W-1:0] slot_q;

  always_comb begin
    if (table_size_i == '0) begin
      n_eff = SIZE_W'(1);
    end else if (32'(table_size_i) > 32'(MAX_SLOTS)) begin
      n_eff = SIZE_W'(MAX_SLOTS);
    end else begin
      n_eff = SIZE_W'(table_size_i);
    end
  end

  // Radix-16 restoring remainder: four compare and subtract steps per cycle.
  always_comb begin
    mod_t = rem_q;
    mod_w = '0;
    for (int i = 0; i < MOD_BITS; i++) begin
      mod_w = {mod_t, key_sh_q[KEY_PAD_W-1-i]};
      if (mod_w >= {1'b0, n_eff}) begin
        mod_w = mod_w - {1'b0, n_eff};
      end
      mod_t = mod_w[SIZE_W-1:0];
    end
    rem_d = mod_t;
  end

  assign pos_inc = SIZE_W'(pos_q) + SIZE_W'(1);
  assign pos_nx  = (pos_inc == n_eff) ? '0 : pos_inc[SLOT_W-1:0];

  always_ff @(posedge clk_i) begin
    if (cmd_i.load) begin
      key_q    <= key_i;
      type_q   <= req_type_i;
      key_sh_q <= {1'b0, key_i};
      rem_q    <= '0;
    end else if (cmd_i.mod_step) begin
      key_sh_q <= {key_sh_q[KEY_PAD_W-MOD_BITS-1:0], {MOD_BITS{1'b0}}};
      rem_q    <= rem_d;
    end
    if (cmd_i.seed) begin
      pos_q <= rem_q[SLOT_W-1:0];
      cnt_q <= '0;
    end else if (cmd_i.advance) begin
      pos_q <= pos_nx;
      cnt_q <= cnt_q + SLOT_W'(1);
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.write) begin
      keys_mem[pos_q] <= key_q;
    end
    if (cmd_i.read) begin
      rd_key_q <= keys_mem[pos_q];
      rd_occ_q <= occ_q[pos_q];
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      occ_q <= '0;
    end else if (cmd_i.write) begin
      occ_q[pos_q] <= 1'b1;
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.result_load) begin
      status_q <= cmd_i.result_status;
      if (cmd_i.result_status == ST_INSERTED || cmd_i.result_status == ST_FOUND) begin
        slot_q <= SLOT_IDX_W'(32'(pos_q));
      end else begin
        slot_q <= '0;
      end
    end
  end

  assign stat_o.is_search = (type_q == REQ_SEARCH);
  assign stat_o.occ       = rd_occ_q;
  assign stat_o.match     = (rd_key_q == key_q);
  assign stat_o.last      = (SIZE_W'(cnt_q) == n_eff - SIZE_W'(1));

  assign status_o     = status_q;
  assign slot_index_o = slot_q;

  a_write_empty: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cmd_i.write |-> !occ_q[pos_q])
    else $error("insert overwrites an occupied slot");

  a_pos_in_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cmd_i.read |-> (SIZE_W'(pos_q) < n_eff) && (SIZE_W'(cnt_q) < n_eff))
    else $error("probe walks outside the table");

  a_write_stores: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cmd_i.write |=> occ_q[$past(pos_q)])
    else $error("inserted slot not marked occupied");

endmodule

>>> hdl/lpht_ctrl.sv
// Controller state machine of the hash table and the result handshake.
module lpht_ctrl
  import lpht_pkg::*;
(
  input  logic  clk_i,
  input  logic  rst_ni,
  input  logic  in_valid_i,
  output logic  in_ready_o,
  output logic  out_valid_o,
  input  logic  out_ready_i,
  input  stat_t stat_i,
  output cmd_t  cmd_o
);

  fsm_e                 state_q, state_d;
  logic [MOD_CNT_W-1:0] mod_cnt_q, mod_cnt_d;
  logic                 out_valid_q, out_valid_d;
  logic                 out_free;
  logic                 decided;
  logic                 do_write;
  status_e              code;

  assign out_free = !out_valid_q || out_ready_i;

  always_comb begin
    decided  = 1'b0;
    do_write = 1'b0;
    code     = ST_MISSING;
    if (!stat_i.is_search) begin
      if (!stat_i.occ) begin
        decided  = 1'b1;
        do_write = 1'b1;
        code     = ST_INSERTED;
      end else if (stat_i.last) begin
        decided = 1'b1;
        code    = ST_FULL;
      end
    end else begin
      if (!stat_i.occ) begin
        decided = 1'b1;
        code    = ST_MISSING;
      end else if (stat_i.match) begin
        decided = 1'b1;
        code    = ST_FOUND;
      end else if (stat_i.last) begin
        decided = 1'b1;
        code    = ST_MISSING;
      end
    end
  end

  always_comb begin
    state_d = state_q;
    case (state_q)
      FSM_IDLE: begin
        if (in_valid_i) begin
          state_d = FSM_MODULO;
        end
      end
      FSM_MODULO: begin
        if (mod_cnt_q == MOD_CNT_W'(MOD_STEPS - 1)) begin
          state_d = FSM_SEED;
        end
      end
      FSM_SEED: state_d = FSM_READ;
      FSM_READ: state_d = FSM_CHECK;
      FSM_CHECK: begin
        if (!decided) begin
          state_d = FSM_READ;
        end else if (out_free) begin
          state_d = FSM_IDLE;
        end
      end
      default: state_d = FSM_IDLE;
    endcase
  end

  always_comb begin
    cmd_o               = '0;
    cmd_o.result_status = code;
    in_ready_o          = 1'b0;
    mod_cnt_d           = mod_cnt_q;
    case (state_q)
      FSM_IDLE: begin
        in_ready_o = 1'b1;
        cmd_o.load = in_valid_i;
        mod_cnt_d  = '0;
      end
      FSM_MODULO: begin
        cmd_o.mod_step = 1'b1;
        mod_cnt_d      = mod_cnt_q + MOD_CNT_W'(1);
      end
      FSM_SEED:  cmd_o.seed = 1'b1;
      FSM_READ:  cmd_o.read = 1'b1;
      FSM_CHECK: begin
        if (!decided) begin
          cmd_o.advance = 1'b1;
        end else if (out_free) begin
          cmd_o.result_load = 1'b1;
          cmd_o.write       = do_write;
        end
      end
      default: begin
        cmd_o = '0;
      end
    endcase
  end

  always_comb begin
    if (cmd_o.result_load) begin
      out_valid_d = 1'b1;
    end else if (out_ready_i) begin
      out_valid_d = 1'b0;
    end else begin
      out_valid_d = out_valid_q;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= FSM_IDLE;
      mod_cnt_q   <= '0;
      out_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      mod_cnt_q   <= mod_cnt_d;
      out_valid_q <= out_valid_d;
    end
  end

  assign out_valid_o = out_valid_q;

  a_no_overrun: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cmd_o.result_load |-> (!out_valid_q || out_ready_i))
    else $error("result beat overwrites a pending beat");

endmodule

>>> hdl/linear_probe_hash_table.sv
// Top level of the linear probing hash table with its configuration port.
// An item passes through the modulo steps and a seed step, then a read and a check for each
// probed slot. The result is registered once a check decides and the result register is free.
// One item is worked on at a time; the next one is accepted while a result beat still waits.
// Reset clears the occupied flags and sets the table size to 10; stored keys are not cleared.
module linear_probe_hash_table
  import lpht_pkg::*;
(
  input  logic                  clk_i,
  input  logic                  rst_ni,
  input  logic                  in_valid_i,
  output logic                  in_ready_o,
  input  logic                  req_type_i,
  input  logic [KEY_W-1:0]      key_i,
  output logic                  out_valid_o,
  input  logic                  out_ready_i,
  output logic [1:0]            status_o,
  output logic [SLOT_IDX_W-1:0] slot_index_o,
  input  logic                  psel,
  input  logic                  penable,
  input  logic                  pwrite,
  input  logic [PADDR_W-1:0]    paddr,
  input  logic [PDATA_W-1:0]    pwdata,
  output logic [PDATA_W-1:0]    prdata,
  output logic                  pready
);

  logic [TS_W-1:0] table_size_q;
  logic            reg_sel;
  cmd_t            cmd;
  stat_t           stat;

  assign reg_sel = (paddr[PADDR_W-1] == REG_IDX_TABLE_SIZE);
  assign pready  = 1'b1;
  assign prdata  = reg_sel ? PDATA_W'(table_size_q) : '0;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      table_size_q <= TABLE_SIZE_RESET;
    end else if (psel && penable && pwrite && pready && reg_sel) begin
      table_size_q <= pwdata[TS_W-1:0];
    end
  end

  lpht_ctrl u_ctrl (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (in_valid_i),
    .in_ready_o  (in_ready_o),
    .out_valid_o (out_valid_o),
    .out_ready_i (out_ready_i),
    .stat_i      (stat),
    .cmd_o       (cmd)
  );

  lpht_dp u_dp (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .cmd_i        (cmd),
    .stat_o       (stat),
    .table_size_i (table_size_q),
    .req_type_i   (req_type_i),
    .key_i        (key_i),
    .status_o     (status_o),
    .slot_index_o (slot_index_o)
  );

endmodule
